>>> rtl/i2cmts_pkg.sv
// Types and codes for the I2C master transfer sequencer.
// No dependencies; imported by the core and the top level.
package i2cmts_pkg;

  localparam logic [1:0] MODE_TX     = 2'd0;
  localparam logic [1:0] MODE_RX     = 2'd1;
  localparam logic [1:0] MODE_STATUS = 2'd2;
  localparam logic [1:0] MODE_ERROR  = 2'd3;

  localparam int ST_SB     = 0;
  localparam int ST_ADDR   = 1;
  localparam int ST_BTF    = 2;
  localparam int ST_STOPF  = 3;
  localparam int ST_TXE    = 4;
  localparam int ST_RXNE   = 5;
  localparam int ST_MASTER = 6;
  localparam int ST_TRANS  = 7;

  localparam int EV_TX_DONE  = 0;
  localparam int EV_RX_DONE  = 1;
  localparam int EV_STOP     = 2;
  localparam int EV_SLAVE_RQ = 3;
  localparam int EV_SLAVE_RX = 4;

  localparam logic REG_ACK_CONTROL = 1'b0;

  typedef enum logic [1:0] {
    XFER_READY = 2'd0,
    XFER_TX    = 2'd1,
    XFER_RX    = 2'd2
  } xfer_state_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] slave_addr;
    logic [7:0] length;
    logic       repeated_start;
    logic [7:0] tx_byte;
    logic [7:0] bus_data;
    logic [7:0] status_flags;
    logic [4:0] error_flags;
  } item_t;

  typedef struct packed {
    logic [1:0] prior_busy;
    logic       start_request;
    logic       data_write;
    logic [7:0] data_value;
    logic       stop_request;
    logic       ack_bit;
    logic       clear_address;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       tx_taken;
    logic [4:0] event_mask;
    logic [4:0] error_mask;
  } result_t;

endpackage

>>> rtl/i2cmts_core.sv
// Transfer state registers and the single-pass step logic for one beat.
// Depends on i2cmts_pkg.
module i2cmts_core import i2cmts_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  logic    ack_control,
  output result_t result
);

  xfer_state_t xfer_state, xfer_state_next;
  logic [7:0]  tx_left, tx_left_next;
  logic [7:0]  rx_left, rx_left_next;
  logic [7:0]  rx_total, rx_total_next;
  logic [6:0]  target_addr, target_addr_next;
  logic        keep_bus, keep_bus_next;
  logic        event_irq_on, event_irq_on_next;
  logic        buffer_irq_on, buffer_irq_on_next;
  logic        error_irq_on, error_irq_on_next;
  logic        ack_on, ack_on_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      xfer_state    <= XFER_READY;
      tx_left       <= '0;
      rx_left       <= '0;
      rx_total      <= '0;
      target_addr   <= '0;
      keep_bus      <= 1'b0;
      event_irq_on  <= 1'b0;
      buffer_irq_on <= 1'b0;
      error_irq_on  <= 1'b0;
      ack_on        <= 1'b1;
    end else if (fire) begin
      xfer_state    <= xfer_state_next;
      tx_left       <= tx_left_next;
      rx_left       <= rx_left_next;
      rx_total      <= rx_total_next;
      target_addr   <= target_addr_next;
      keep_bus      <= keep_bus_next;
      event_irq_on  <= event_irq_on_next;
      buffer_irq_on <= buffer_irq_on_next;
      error_irq_on  <= error_irq_on_next;
      ack_on        <= ack_on_next;
    end
  end

  always_comb begin
    logic       evt_on;
    logic       buf_on;
    logic       master;
    logic       trans;
    logic [7:0] st;
    st     = item.status_flags;
    evt_on = event_irq_on;
    buf_on = buffer_irq_on;
    master = st[ST_MASTER];
    trans  = st[ST_TRANS];

    xfer_state_next    = xfer_state;
    tx_left_next       = tx_left;
    rx_left_next       = rx_left;
    rx_total_next      = rx_total;
    target_addr_next   = target_addr;
    keep_bus_next      = keep_bus;
    event_irq_on_next  = event_irq_on;
    buffer_irq_on_next = buffer_irq_on;
    error_irq_on_next  = error_irq_on;
    ack_on_next        = ack_on;

    result            = '0;
    result.prior_busy = xfer_state;

    unique case (item.mode)
      MODE_TX, MODE_RX: begin
        if (xfer_state != XFER_TX && xfer_state != XFER_RX) begin
          target_addr_next = item.slave_addr;
          keep_bus_next    = item.repeated_start;
          if (item.mode == MODE_TX) begin
            tx_left_next    = item.length;
            xfer_state_next = XFER_TX;
          end else begin
            rx_left_next    = item.length;
            rx_total_next   = item.length;
            xfer_state_next = XFER_RX;
          end
          result.start_request = 1'b1;
          event_irq_on_next    = 1'b1;
          buffer_irq_on_next   = 1'b1;
          error_irq_on_next    = 1'b1;
        end
      end
      MODE_STATUS: begin
        if (evt_on && st[ST_SB]) begin
          if (xfer_state == XFER_TX) begin
            result.data_write = 1'b1;
            result.data_value = {target_addr, 1'b0};
          end else if (xfer_state == XFER_RX) begin
            result.data_write = 1'b1;
            result.data_value = {target_addr, 1'b1};
          end
        end
        if (evt_on && st[ST_ADDR]) begin
          if (master && xfer_state == XFER_RX && rx_total == 8'd1) ack_on_next = 1'b0;
          result.clear_address = 1'b1;
        end
        if (evt_on && st[ST_BTF]) begin
          if (xfer_state == XFER_TX && st[ST_TXE] && tx_left == 8'd0) begin
            if (!keep_bus) result.stop_request = 1'b1;
            event_irq_on_next  = 1'b0;
            buffer_irq_on_next = 1'b0;
            xfer_state_next    = XFER_READY;
            tx_left_next       = '0;
            result.event_mask[EV_TX_DONE] = 1'b1;
          end
        end
        if (evt_on && st[ST_STOPF]) result.event_mask[EV_STOP] = 1'b1;
        if (evt_on && buf_on && st[ST_TXE]) begin
          if (master) begin
            if (xfer_state_next == XFER_TX && tx_left_next != 8'd0) begin
              result.data_write = 1'b1;
              result.data_value = item.tx_byte;
              result.tx_taken   = 1'b1;
              tx_left_next      = tx_left_next - 8'd1;
            end
          end else if (trans) begin
            result.event_mask[EV_SLAVE_RQ] = 1'b1;
          end
        end
        if (evt_on && buf_on && st[ST_RXNE]) begin
          if (master) begin
            if (xfer_state_next == XFER_RX) begin
              if (rx_total != 8'd0) begin
                if (rx_total > 8'd1 && rx_left == 8'd2) ack_on_next = 1'b0;
                result.rx_valid = 1'b1;
                result.rx_data  = item.bus_data;
                rx_left_next    = rx_left - 8'd1;
              end
              if (rx_left_next == 8'd0) begin
                if (!keep_bus) result.stop_request = 1'b1;
                event_irq_on_next  = 1'b0;
                buffer_irq_on_next = 1'b0;
                xfer_state_next    = XFER_READY;
                rx_left_next       = '0;
                rx_total_next      = '0;
                if (ack_control) ack_on_next = 1'b1;
                result.event_mask[EV_RX_DONE] = 1'b1;
              end
            end
          end else if (!trans) begin
            result.event_mask[EV_SLAVE_RX] = 1'b1;
          end
        end
      end
      MODE_ERROR: begin
        if (error_irq_on) result.error_mask = item.error_flags;
      end
      default: begin
      end
    endcase

    result.ack_bit = ack_on_next;
  end

endmodule

>>> rtl/i2c_master_transfer_sequencer.sv
// Top level of the I2C master transfer sequencer: APB register, input beat
// register, output beat register. Depends on i2cmts_pkg and i2cmts_core.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   input    | in_valid / in_stall  | mode .. error_flags
//   output   | out_valid / out_stall| prior_busy .. error_mask
//   config   | APB psel/penable     | ack_control at byte address 0
//
// One beat per cycle while not stalled; beats pass the input, then the output register.
// The step logic in the core runs once per beat as it moves between the two registers.
// rst is synchronous: transfer state goes ready, interrupts off, ack_control and ACK on.
// A stalled output holds its beat; the input register still takes one more beat.
module i2c_master_transfer_sequencer import i2cmts_pkg::*; (
  input  logic        clk,
  input  logic        rst,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [6:0]  slave_addr,
  input  logic [7:0]  length,
  input  logic        repeated_start,
  input  logic [7:0]  tx_byte,
  input  logic [7:0]  bus_data,
  input  logic [7:0]  status_flags,
  input  logic [4:0]  error_flags,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  prior_busy,
  output logic        start_request,
  output logic        data_write,
  output logic [7:0]  data_value,
  output logic        stop_request,
  output logic        ack_bit,
  output logic        clear_address,
  output logic        rx_valid,
  output logic [7:0]  rx_data,
  output logic        tx_taken,
  output logic [4:0]  event_mask,
  output logic [4:0]  error_mask
);

  logic    ack_control;
  logic    s1_valid;
  item_t   s1_item;
  result_t step_result;
  result_t out_beat;
  logic    advance;
  logic    cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_ACK_CONTROL);
  assign prdata    = (paddr[2] == REG_ACK_CONTROL) ? {31'd0, ack_control} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) ack_control <= 1'b1;
    else if (cfg_write) ack_control <= pwdata[0];
  end

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= (in_valid && !in_stall) || (s1_valid && !advance);
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= '{mode: mode, slave_addr: slave_addr, length: length,
                   repeated_start: repeated_start, tx_byte: tx_byte,
                   bus_data: bus_data, status_flags: status_flags,
                   error_flags: error_flags};
    end
    if (advance) out_beat <= step_result;
  end

  i2cmts_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (advance),
    .item        (s1_item),
    .ack_control (ack_control),
    .result      (step_result)
  );

  assign prior_busy    = out_beat.prior_busy;
  assign start_request = out_beat.start_request;
  assign data_write    = out_beat.data_write;
  assign data_value    = out_beat.data_value;
  assign stop_request  = out_beat.stop_request;
  assign ack_bit       = out_beat.ack_bit;
  assign clear_address = out_beat.clear_address;
  assign rx_valid      = out_beat.rx_valid;
  assign rx_data       = out_beat.rx_data;
  assign tx_taken      = out_beat.tx_taken;
  assign event_mask    = out_beat.event_mask;
  assign error_mask    = out_beat.error_mask;

  a_start_from_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && start_request |-> prior_busy == 2'(XFER_READY))
    else $error("start request while busy");

  a_taken_writes: assert property (@(posedge clk) disable iff (rst)
    out_valid && tx_taken |-> data_write && !rx_valid)
    else $error("tx byte taken without data write");

  a_start_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && start_request |-> !rx_valid && !data_write && !stop_request)
    else $error("start request mixed with event actions");

  a_beat_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> s1_valid)
    else $error("input register lost a stalled beat");

endmodule
